FILE: src/aus_pkg.sv
`default_nettype none

package aus_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_UNIT       = 2'd0;
  localparam logic [1:0] STATUS_FINAL_UNIT = 2'd1;
  localparam logic [1:0] STATUS_NO_START   = 2'd2;

  // Configuration register indexes
  localparam int unsigned REG_CODEC_IS_H265 = 0;

  // One input byte of the stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  // One result: an access unit or an end-of-stream status
  typedef struct packed {
    logic [31:0] unit_begin;
    logic [31:0] unit_end;
    logic [1:0]  status;
    logic        last_of_run;
  } out_item_t;

  // Up to two results handed from the parser to the output queue per byte
  typedef struct packed {
    logic      push_a;
    logic      push_b;
    out_item_t res_a;
    out_item_t res_b;
  } push_t;

endpackage

`default_nettype wire

FILE: src/aus_parse.sv
`default_nettype none

module aus_parse #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire aus_pkg::in_item_t item_i,
  input  wire logic              codec_is_h265_i,
  output aus_pkg::push_t         push_o
);

  localparam logic [OFFSET_BITS-1:0] OffsetMax = '1;
  localparam logic [OFFSET_BITS-1:0] OffsetTwo = OFFSET_BITS'(2);

  logic [1:0]             zero_run_q, zero_run_d;
  logic                   hdr_pend_q, hdr_pend_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] code_pos_q, code_pos_d;
  logic [OFFSET_BITS-1:0] unit_begin_q, unit_begin_d;
  logic                   has_pic_q, has_pic_d;
  logic                   seen_q, seen_d;

  logic                   vcl;
  logic                   split;
  logic                   is_code;
  logic                   seen_now;
  logic [OFFSET_BITS-1:0] code;
  logic [OFFSET_BITS-1:0] begin_hdr;
  logic [OFFSET_BITS-1:0] begin_now;
  logic [OFFSET_BITS-1:0] pos_next;
  logic [4:0]             h264_type;
  logic [5:0]             h265_type;
  aus_pkg::out_item_t     split_res;
  aus_pkg::out_item_t     final_res;

  // Reduce an offset to the 32-bit result field
  function automatic logic [31:0] to_field(input logic [OFFSET_BITS-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[31:0];
  endfunction

  // Classify the NAL header byte for the selected codec
  assign h264_type = item_i.data_byte[4:0];
  assign h265_type = item_i.data_byte[6:1];
  assign vcl = codec_is_h265_i ? (h265_type <= 6'd31) : (h264_type inside {[5'd1:5'd5]});

  // Split on a second picture unit; detect start codes
  assign split     = hdr_pend_q && vcl && has_pic_q;
  assign is_code   = (item_i.data_byte == 8'h01) && (zero_run_q == 2'd2);
  assign code      = (pos_q >= OffsetTwo) ? (pos_q - OffsetTwo) : '0;
  assign begin_hdr = split ? code_pos_q : unit_begin_q;
  assign begin_now = (is_code && !seen_q) ? code : begin_hdr;
  assign seen_now  = seen_q || is_code;
  assign pos_next  = (pos_q != OffsetMax) ? (pos_q + OFFSET_BITS'(1)) : pos_q;

  // Next parser state; clear the stream on its final byte
  always_comb begin
    zero_run_d   = zero_run_q;
    hdr_pend_d   = hdr_pend_q;
    pos_d        = pos_q;
    code_pos_d   = code_pos_q;
    unit_begin_d = unit_begin_q;
    has_pic_d    = has_pic_q;
    seen_d       = seen_q;
    if (accept_i) begin
      if (item_i.data_byte == 8'h00) begin
        if (zero_run_q != 2'd2) begin
          zero_run_d = zero_run_q + 2'd1;
        end
      end else begin
        zero_run_d = '0;
      end
      hdr_pend_d   = is_code;
      pos_d        = pos_next;
      code_pos_d   = is_code ? code : code_pos_q;
      unit_begin_d = begin_now;
      has_pic_d    = has_pic_q || (hdr_pend_q && vcl);
      seen_d       = seen_now;
      if (item_i.end_of_stream) begin
        zero_run_d   = '0;
        hdr_pend_d   = 1'b0;
        pos_d        = '0;
        code_pos_d   = '0;
        unit_begin_d = '0;
        has_pic_d    = 1'b0;
        seen_d       = 1'b0;
      end
    end
  end

  // Build the results of this byte; a lone result always goes in slot a
  always_comb begin
    split_res.unit_begin  = to_field(unit_begin_q);
    split_res.unit_end    = to_field(code_pos_q);
    split_res.status      = aus_pkg::STATUS_UNIT;
    split_res.last_of_run = !item_i.end_of_stream;
    if (seen_now) begin
      final_res.unit_begin = to_field(begin_now);
      final_res.unit_end   = to_field(pos_next);
      final_res.status     = aus_pkg::STATUS_FINAL_UNIT;
    end else begin
      final_res.unit_begin = '0;
      final_res.unit_end   = '0;
      final_res.status     = aus_pkg::STATUS_NO_START;
    end
    final_res.last_of_run = 1'b1;
    push_o.push_a = accept_i && (split || item_i.end_of_stream);
    push_o.push_b = accept_i && split && item_i.end_of_stream;
    push_o.res_a  = split ? split_res : final_res;
    push_o.res_b  = final_res;
  end

  // Hold the parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q   <= '0;
      hdr_pend_q   <= 1'b0;
      pos_q        <= '0;
      code_pos_q   <= '0;
      unit_begin_q <= '0;
      has_pic_q    <= 1'b0;
      seen_q       <= 1'b0;
    end else begin
      zero_run_q   <= zero_run_d;
      hdr_pend_q   <= hdr_pend_d;
      pos_q        <= pos_d;
      code_pos_q   <= code_pos_d;
      unit_begin_q <= unit_begin_d;
      has_pic_q    <= has_pic_d;
      seen_q       <= seen_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/aus_out_fifo.sv
`default_nettype none

module aus_out_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire aus_pkg::push_t push_i,
  input  wire logic           pop_i,
  output wire logic           room_o,
  output wire logic           valid_o,
  output aus_pkg::out_item_t  data_o
);

  localparam int unsigned Depth = 4;

  aus_pkg::out_item_t mem_q [Depth];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       do_pop;
  logic [1:0] n_push;
  logic [1:0] wr_ptr_b;

  assign valid_o = (count_q != 3'd0);
  assign data_o  = mem_q[rd_ptr_q];
  // Leave space for the worst case of two results from one byte
  assign room_o  = (count_q <= 3'(Depth - 2));
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    n_push   = 2'(push_i.push_a) + 2'(push_i.push_b);
    wr_ptr_b = wr_ptr_q + 2'd1;
    wr_ptr_d = wr_ptr_q + n_push;
    rd_ptr_d = rd_ptr_q + 2'(do_pop);
    count_d  = count_q + 3'(n_push) - 3'(do_pop);
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store results; the second one lands in the next slot
  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[wr_ptr_q] <= push_i.res_a;
    end
    if (push_i.push_b) begin
      mem_q[wr_ptr_b] <= push_i.res_b;
    end
  end

endmodule

`default_nettype wire

FILE: src/annexb_access_unit_splitter.sv
`default_nettype none

// Annex-B access unit splitter. Takes an H.264 or H.265 byte stream, one
// byte per transfer, finds 00 00 01 start codes and classifies the NAL
// header byte after each one (codec chosen by register 0, bit 0, at byte
// address 0). Each finished access unit comes out as its begin offset (its
// first start code) and end offset; the byte flagged end_of_stream also
// produces the final unit, or a no-start-code status, and clears the stream
// state. One byte is accepted per clock while the output queue has room;
// the parser state updates in the cycle of the transfer and results reach
// the output in the cycle after it. A byte yields at most two results,
// which go through a four-entry output queue drained at one result per
// clock while out_ready_i is high; in_ready_o drops only above two results.
module annexb_access_unit_splitter #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Byte input
  input  wire logic               in_valid_i,
  output wire logic               in_ready_o,
  input  wire aus_pkg::in_item_t  in_data_i,
  // Result output
  output wire logic               out_valid_o,
  input  wire logic               out_ready_i,
  output aus_pkg::out_item_t      out_data_o,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output wire logic [31:0]        prdata,
  output wire logic               pready
);

  logic           codec_q;
  logic           cfg_wr;
  logic           accept;
  aus_pkg::push_t push;
  logic           room;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == 1'(aus_pkg::REG_CODEC_IS_H265));
  assign prdata = (paddr[2] == 1'(aus_pkg::REG_CODEC_IS_H265)) ?
                  {31'd0, codec_q} : 32'd0;

  // Hold the codec select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q <= 1'b0;
    end else if (cfg_wr) begin
      codec_q <= pwdata[0];
    end
  end

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  aus_parse #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (in_data_i),
    .codec_is_h265_i(codec_q),
    .push_o         (push)
  );

  aus_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (out_ready_i),
    .room_o (room),
    .valid_o(out_valid_o),
    .data_o (out_data_o)
  );

endmodule

`default_nettype wire

FILE: tb/annexb_access_unit_splitter_test.sv
`default_nettype none

// Tracks the Annex-B parsing state of the stream and keeps the access units
// that the block still owes, in the order they must come out.
class au_scoreboard;
  bit                 codec_h265;
  logic [1:0]         zero_run;
  bit                 header_pending;
  logic [31:0]        byte_pos;
  logic [31:0]        code_pos;
  logic [31:0]        unit_begin;
  bit                 unit_has_picture;
  bit                 code_seen;
  aus_pkg::out_item_t owed_units[$];
  int unsigned        failures;

  function new();
    codec_h265 = 1'b0;
    failures   = 0;
    clear_stream();
  endfunction

  function void clear_stream();
    zero_run         = 2'd0;
    header_pending   = 1'b0;
    byte_pos         = '0;
    code_pos         = '0;
    unit_begin       = '0;
    unit_has_picture = 1'b0;
    code_seen        = 1'b0;
  endfunction

  function int unsigned pending();
    return owed_units.size();
  endfunction

  // Classify a NAL header byte as coded picture or not
  function bit is_picture(logic [7:0] hdr);
    logic [5:0] type265;
    logic [4:0] type264;
    if (codec_h265) begin
      type265 = hdr[6:1];
      return type265 <= 6'd31;
    end
    type264 = hdr[4:0];
    return type264 >= 5'd1 && type264 <= 5'd5;
  endfunction

  // Advance the parser by one transferred byte and queue its results
  function void note_byte(aus_pkg::in_item_t item);
    aus_pkg::out_item_t res [2];
    logic [31:0]        pos;
    logic [31:0]        code;
    bit                 vcl;
    int                 n;
    n   = 0;
    pos = byte_pos;

    // Header byte after a start code: split on a second picture
    if (header_pending) begin
      vcl            = is_picture(item.data_byte);
      header_pending = 1'b0;
      if (vcl && unit_has_picture) begin
        res[n].unit_begin  = unit_begin;
        res[n].unit_end    = code_pos;
        res[n].status      = aus_pkg::STATUS_UNIT;
        res[n].last_of_run = 1'b0;
        n++;
        unit_begin = code_pos;
      end
      if (vcl) unit_has_picture = 1'b1;
    end

    // Start code search
    if (item.data_byte == 8'h00) begin
      if (zero_run < 2'd2) zero_run++;
    end else begin
      if (item.data_byte == 8'h01 && zero_run == 2'd2) begin
        code = (pos >= 32'd2) ? pos - 32'd2 : 32'd0;
        if (!code_seen) begin
          code_seen  = 1'b1;
          unit_begin = code;
        end
        code_pos       = code;
        header_pending = 1'b1;
      end
      zero_run = 2'd0;
    end

    if (byte_pos != '1) byte_pos++;

    // Close the stream
    if (item.end_of_stream) begin
      if (code_seen) begin
        res[n].unit_begin = unit_begin;
        res[n].unit_end   = byte_pos;
        res[n].status     = aus_pkg::STATUS_FINAL_UNIT;
      end else begin
        res[n].unit_begin = '0;
        res[n].unit_end   = '0;
        res[n].status     = aus_pkg::STATUS_NO_START;
      end
      res[n].last_of_run = 1'b0;
      n++;
      clear_stream();
    end

    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) owed_units.insert(owed_units.size(), res[k]);
  endfunction

  // Compare one transferred result with the oldest owed unit
  function void check_result(aus_pkg::out_item_t got);
    aus_pkg::out_item_t want;
    if (owed_units.size() == 0) begin
      $error("unexpected result: begin %0d end %0d status %0d", got.unit_begin,
             got.unit_end, got.status);
      failures++;
      return;
    end
    want = owed_units.pop_front();
    if (got.unit_begin !== want.unit_begin) begin
      $error("unit_begin: expected %0d, got %0d", want.unit_begin, got.unit_begin);
      failures++;
    end
    if (got.unit_end !== want.unit_end) begin
      $error("unit_end: expected %0d, got %0d", want.unit_end, got.unit_end);
      failures++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      failures++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
      failures++;
    end
  endfunction
endclass

module annexb_access_unit_splitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [2:0]  CODEC_ADDR  = 3'(4 * aus_pkg::REG_CODEC_IS_H265);
  localparam logic [2:0]  SPARE_ADDR  = 3'(4 * (aus_pkg::REG_CODEC_IS_H265 + 1));

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  aus_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  aus_pkg::out_item_t out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  au_scoreboard       sb;
  logic [7:0]         stream_bytes[$];
  int unsigned        bytes_sent;
  int unsigned        quiet_cycles;
  bit                 tx_calm;
  bit                 rx_calm;

  annexb_access_unit_splitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Observe transfers on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_byte(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result sink with random stalls
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Select the codec, with junk in the unused bits, and read it back
  task automatic program_codec(input bit h265);
    logic [31:0] readback;
    apb_write(CODEC_ADDR, {31'($urandom() >> 1), h265});
    sb.codec_h265 = h265;
    apb_read(CODEC_ADDR, readback);
    if (readback[0] !== h265) begin
      $error("codec_is_h265: expected %0d, got %0d", h265, readback[0]);
      sb.failures++;
    end
  endtask

  // Send one byte; valid stays high until the next byte or a gap
  task automatic push_byte(input logic [7:0] data, input logic eos);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i              <= 1'b1;
    in_data_i.data_byte     <= data;
    in_data_i.end_of_stream <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_bytes.size(); i++)
      push_byte(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  // Hold the input until every owed unit has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Append one byte to the stream under construction
  function automatic void add_byte(input logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endfunction

  // NAL header biased toward picture units of the current codec
  function automatic logic [7:0] pick_header();
    logic [7:0] hdr;
    int         kind;
    hdr  = 8'($urandom());
    kind = $urandom_range(0, 3);
    if (sb.codec_h265) begin
      if (kind < 2) hdr[6] = 1'b0;
      else if (kind == 2) hdr[6] = 1'b1;
    end else begin
      if (kind < 2) hdr[4:0] = 5'($urandom_range(1, 5));
      else if (kind == 2) hdr[4:0] = ($urandom_range(0, 4) == 0) ? 5'd0 : 5'($urandom_range(6, 31));
    end
    return hdr;
  endfunction

  // Build a random stream: mostly well formed, some noise or cut short
  task automatic build_stream();
    int kind;
    int nals;
    int len;
    stream_bytes.delete();
    kind = $urandom_range(0, 7);
    if (kind == 0) begin
      len = $urandom_range(1, 24);
      repeat (len) begin
        case ($urandom_range(0, 5))
          0, 1, 2: add_byte(8'h00);
          3:       add_byte(8'h01);
          default: add_byte(8'($urandom()));
        endcase
      end
      return;
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(2, 255)));
    nals = $urandom_range(1, 6);
    repeat (nals) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(3, 4) : 2) add_byte(8'h00);
      add_byte(8'h01);
      add_byte(pick_header());
      repeat ($urandom_range(0, 10)) begin
        if ($urandom_range(0, 7) == 0) add_byte(8'h00);
        else add_byte(8'($urandom()));
      end
    end
    // Cut short, possibly right after a start code
    if (kind == 1) begin
      len = $urandom_range(1, stream_bytes.size());
      while (stream_bytes.size() > len) void'(stream_bytes.pop_back());
    end
  endtask

  initial begin
    logic [31:0] spare;
    sb           = new();
    bytes_sent   = 0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // H.264 rules; a write past the last register must change nothing
    program_codec(1'b0);
    spare = $urandom();
    apb_write(SPARE_ADDR, spare | 32'h1);
    program_codec(1'b0);

    // No start code in the whole stream
    stream_bytes = '{8'hFF};
    send_stream();
    // Start code with no header before the end
    stream_bytes = '{8'h00, 8'h00, 8'h01};
    send_stream();
    // Picture, zero header feeding the next code, split, split on the final byte
    stream_bytes = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01, 8'h00,
                     8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h01, 8'hE1};
    send_stream();
    drain();

    // H.265 rules: picture type 19, then type 1 on the final byte
    program_codec(1'b1);
    stream_bytes = '{8'h00, 8'h00, 8'h01, 8'h26, 8'h00, 8'h00, 8'h01, 8'h02};
    send_stream();
    drain();

    // Random streams, alternating codec between phases
    for (int ph = 0; ph < 4; ph++) begin
      program_codec(ph % 2 == 0);
      while (bytes_sent < 27 + (ph + 1) * 381) begin
        tx_calm = ($urandom_range(0, 5) == 0);
        build_stream();
        send_stream();
        if ($urandom_range(0, 19) == 0) drain();
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
src/aus_pkg.sv
src/aus_parse.sv
src/aus_out_fifo.sv
src/annexb_access_unit_splitter.sv
tb/annexb_access_unit_splitter_test.sv
